[rtl/cwdm_pkg.sv]
// shared types, constants and helpers of the command window delay matcher
// no dependencies; imported by every other rtl file
`default_nettype none

package cwdm_pkg;

  localparam int unsigned DEFAULT_WINDOW_DEPTH = 32;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned AGE_W = 6;
  localparam int unsigned WLEN_W = 6;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 6'd20;
  localparam logic [ANGLE_W-1:0] OUTLIER_THRESHOLD_RESET = 16'd2048;

  // configuration register indexes
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_OUTLIER_THRESHOLD = 1'b1;

  // input item modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  typedef struct packed {
    logic mode;
    logic signed [ANGLE_W-1:0] roll_value;
    logic signed [ANGLE_W-1:0] pitch_value;
  } cmd_item_t;

  typedef struct packed {
    logic match_valid;
    logic [ANGLE_W-1:0] roll_min_diff;
    logic [AGE_W-1:0] roll_age;
    logic [ANGLE_W-1:0] pitch_min_diff;
    logic [AGE_W-1:0] pitch_age;
  } match_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
  } entry_t;

  typedef struct packed {
    logic take;
    logic first;
  } scan_ctrl_t;

  // exact magnitude of the difference of two signed angles
  function automatic logic [ANGLE_W:0] abs_diff(input logic signed [ANGLE_W-1:0] a,
                                               input logic signed [ANGLE_W-1:0] b);
    logic signed [ANGLE_W:0] d;
    d = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
    return d[ANGLE_W] ? (ANGLE_W+1)'(-d) : d;
  endfunction

endpackage

`default_nettype wire

[rtl/cwdm_cell.sv]
// one window cell: holds a roll/pitch command pair and passes it on when shifted
// depends on cwdm_pkg
`default_nettype none

module cwdm_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire cwdm_pkg::entry_t d_i,
  output cwdm_pkg::entry_t     q_o
);
  import cwdm_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

[rtl/cwdm_min_track.sv]
// per-axis running minimum of |entry - measurement| with the age of the best entry
// depends on cwdm_pkg
`default_nettype none

module cwdm_min_track (
  input  wire logic                                  clk_i,
  input  wire cwdm_pkg::scan_ctrl_t                  ctrl_i,
  input  wire logic signed [cwdm_pkg::ANGLE_W-1:0]   entry_i,
  input  wire logic signed [cwdm_pkg::ANGLE_W-1:0]   meas_i,
  input  wire logic [cwdm_pkg::AGE_W-1:0]            age_i,
  output logic [cwdm_pkg::ANGLE_W-1:0]               best_diff_o,
  output logic [cwdm_pkg::AGE_W-1:0]                 best_age_o
);
  import cwdm_pkg::*;

  logic [ANGLE_W:0] diff_full;
  logic [ANGLE_W-1:0] diff;
  logic [ANGLE_W-1:0] best_diff_q;
  logic [AGE_W-1:0] best_age_q;

  assign diff_full = abs_diff(entry_i, meas_i);
  assign diff = diff_full[ANGLE_W-1:0];

  // oldest entry comes first, so strict less keeps the earliest on ties
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && (ctrl_i.first || (diff < best_diff_q))) begin
      best_diff_q <= diff;
      best_age_q <= age_i;
    end
  end

  assign best_diff_o = best_diff_q;
  assign best_age_o = best_age_q;

endmodule

`default_nettype wire

[rtl/command_window_delay_matcher_top.sv]
// command window delay matcher: ring of command cells, two min trackers, control
// depends on cwdm_pkg, cwdm_cell, cwdm_min_track
//
//  port group   | dir | handshake               | payload
//  -------------+-----+-------------------------+-----------------------------
//  in_*         | in  | in_valid_i / in_stall_o | cwdm_pkg::cmd_item_t
//  out_*        | out | out_valid_o/ out_stall_i| cwdm_pkg::match_item_t
//  cfg_*        | in  | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// a push item is taken while idle and the next item may follow at once
// a measurement with a full window rotates the cell ring once in the scan state,
// then hands the result over from the hold state to the output register
// an outlier or a measurement on a window not yet full goes straight to the hold state
// input is stalled during scan and while the result waits for the output register
// reset clears fill count and last attitude and loads config reset values; cells are not reset
`default_nettype none

module command_window_delay_matcher_top #(
  parameter int unsigned WINDOW_DEPTH = cwdm_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire cwdm_pkg::cmd_item_t                 in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output cwdm_pkg::match_item_t                    out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [cwdm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import cwdm_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW = (AW > WLEN_W) ? AW : WLEN_W;
  localparam logic [AW-1:0] DEPTH_A = AW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] ONE_A = AW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q, state_d;
  logic [WLEN_W-1:0] wlen_q;
  logic [ANGLE_W-1:0] thresh_q;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] age_q, age_d;
  logic signed [ANGLE_W-1:0] last_roll_q, last_pitch_q;
  logic res_match_q, res_match_d;
  logic out_valid_q;
  match_item_t out_q;

  logic [AW-1:0] len_eff;
  logic in_acc, push_acc, meas_acc, out_free, outlier, shift;
  logic [ANGLE_W:0] jump_roll, jump_pitch;
  entry_t head_d;
  entry_t cell_q [WINDOW_DEPTH];
  scan_ctrl_t scan_ctrl;
  logic [ANGLE_W-1:0] roll_best, pitch_best;
  logic [AGE_W-1:0] roll_best_age, pitch_best_age;

  // effective length clamped to 1..WINDOW_DEPTH
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = ONE_A;
    end else if (CW'(wlen_q) > CW'(WINDOW_DEPTH)) begin
      len_eff = DEPTH_A;
    end else begin
      len_eff = AW'(wlen_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign push_acc = in_acc && (in_data_i.mode == MODE_PUSH);
  assign meas_acc = in_acc && (in_data_i.mode == MODE_MEASURE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign jump_roll = abs_diff(last_roll_q, in_data_i.roll_value);
  assign jump_pitch = abs_diff(last_pitch_q, in_data_i.pitch_value);
  assign outlier = (jump_roll > {1'b0, thresh_q}) || (jump_pitch > {1'b0, thresh_q});

  // ring: push enters at cell 0, scan feeds the last cell back around
  assign shift = push_acc || (state_q == ST_SCAN);
  always_comb begin
    if (state_q == ST_SCAN) begin
      head_d = cell_q[WINDOW_DEPTH-1];
    end else begin
      head_d.roll = in_data_i.roll_value;
      head_d.pitch = in_data_i.pitch_value;
    end
  end

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    cwdm_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .d_i    ((k == 0) ? head_d : cell_q[(k == 0) ? 0 : k-1]),
      .q_o    (cell_q[k])
    );
  end

  // last cell holds the entry of age age_q during scan
  assign scan_ctrl.take = (state_q == ST_SCAN) && (age_q <= len_eff);
  assign scan_ctrl.first = (age_q == len_eff);

  cwdm_min_track u_roll_track (
    .clk_i      (clk_i),
    .ctrl_i     (scan_ctrl),
    .entry_i    (cell_q[WINDOW_DEPTH-1].roll),
    .meas_i     (last_roll_q),
    .age_i      (AGE_W'(age_q)),
    .best_diff_o(roll_best),
    .best_age_o (roll_best_age)
  );

  cwdm_min_track u_pitch_track (
    .clk_i      (clk_i),
    .ctrl_i     (scan_ctrl),
    .entry_i    (cell_q[WINDOW_DEPTH-1].pitch),
    .meas_i     (last_pitch_q),
    .age_i      (AGE_W'(age_q)),
    .best_diff_o(pitch_best),
    .best_age_o (pitch_best_age)
  );

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    age_d = age_q;
    res_match_d = res_match_q;
    case (state_q)
      ST_IDLE: begin
        if (push_acc) begin
          fill_d = (fill_q >= len_eff) ? len_eff : fill_q + ONE_A;
        end else if (meas_acc) begin
          res_match_d = !outlier && (fill_q >= len_eff);
          age_d = DEPTH_A;
          state_d = res_match_d ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        age_d = age_q - ONE_A;
        if (age_q == ONE_A) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      age_q <= '0;
      res_match_q <= 1'b0;
      last_roll_q <= '0;
      last_pitch_q <= '0;
      wlen_q <= WINDOW_LENGTH_RESET;
      thresh_q <= OUTLIER_THRESHOLD_RESET;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      age_q <= age_d;
      res_match_q <= res_match_d;
      if (meas_acc) begin
        last_roll_q <= in_data_i.roll_value;
        last_pitch_q <= in_data_i.pitch_value;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_LENGTH: wlen_q <= cfg_wdata_i[WLEN_W-1:0];
          REG_OUTLIER_THRESHOLD: thresh_q <= cfg_wdata_i[ANGLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      out_q.match_valid <= res_match_q;
      out_q.roll_min_diff <= res_match_q ? roll_best : '0;
      out_q.roll_age <= res_match_q ? roll_best_age : '0;
      out_q.pitch_min_diff <= res_match_q ? pitch_best : '0;
      out_q.pitch_age <= res_match_q ? pitch_best_age : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

`default_nettype wire
